@@ hdl/rid_pkg.sv @@
`default_nettype none

package rid_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned INDEX_W = 7;

   typedef enum logic [2:0] {
      FMT_NONE = 3'd0,
      FMT_R    = 3'd1,
      FMT_R4   = 3'd2,
      FMT_I    = 3'd3,
      FMT_S    = 3'd4,
      FMT_B    = 3'd5,
      FMT_U    = 3'd6,
      FMT_J    = 3'd7
   } format_class_type;

   // Major opcodes.
   localparam logic [6:0] OPC_LOAD      = 7'b0000011;
   localparam logic [6:0] OPC_MISC_MEM  = 7'b0001111;
   localparam logic [6:0] OPC_OP_IMM    = 7'b0010011;
   localparam logic [6:0] OPC_AUIPC     = 7'b0010111;
   localparam logic [6:0] OPC_OP_IMM_32 = 7'b0011011;
   localparam logic [6:0] OPC_STORE     = 7'b0100011;
   localparam logic [6:0] OPC_STORE_FP  = 7'b0100111;
   localparam logic [6:0] OPC_AMO       = 7'b0101111;
   localparam logic [6:0] OPC_OP        = 7'b0110011;
   localparam logic [6:0] OPC_LUI       = 7'b0110111;
   localparam logic [6:0] OPC_OP_32     = 7'b0111011;
   localparam logic [6:0] OPC_MADD      = 7'b1000011;
   localparam logic [6:0] OPC_MSUB      = 7'b1000111;
   localparam logic [6:0] OPC_NMSUB     = 7'b1001011;
   localparam logic [6:0] OPC_NMADD     = 7'b1001111;
   localparam logic [6:0] OPC_OP_FP     = 7'b1010011;
   localparam logic [6:0] OPC_BRANCH    = 7'b1100011;
   localparam logic [6:0] OPC_JALR      = 7'b1100111;
   localparam logic [6:0] OPC_JAL       = 7'b1101111;
   localparam logic [6:0] OPC_SYSTEM    = 7'b1110011;

   // funct7 codes of the integer groups.
   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;
   localparam logic [6:0] F7_MULDIV = 7'b0000001;

   // funct7 codes of the double-precision group.
   localparam logic [6:0] F7_FADD    = 7'h01;
   localparam logic [6:0] F7_FSUB    = 7'h05;
   localparam logic [6:0] F7_FMUL    = 7'h09;
   localparam logic [6:0] F7_FDIV    = 7'h0D;
   localparam logic [6:0] F7_FSQRT   = 7'h2D;
   localparam logic [6:0] F7_FMV_D_X = 7'h79;
   localparam logic [6:0] F7_FCVT_S  = 7'h20;
   localparam logic [6:0] F7_FCVT_D  = 7'h21;
   localparam logic [6:0] F7_FCVT_I  = 7'h61;
   localparam logic [6:0] F7_FCVT_DI = 7'h69;
   localparam logic [6:0] F7_FSGNJ   = 7'h11;
   localparam logic [6:0] F7_FMINMAX = 7'h15;
   localparam logic [6:0] F7_FCMP    = 7'h51;
   localparam logic [6:0] F7_FCLASS  = 7'h71;

   // funct5 codes of the atomic group, in index order.
   localparam logic [4:0] F5_LR      = 5'h02;
   localparam logic [4:0] F5_SC      = 5'h03;
   localparam logic [4:0] F5_SWAP    = 5'h01;
   localparam logic [4:0] F5_ADD     = 5'h00;
   localparam logic [4:0] F5_XOR     = 5'h04;
   localparam logic [4:0] F5_AND     = 5'h0C;
   localparam logic [4:0] F5_OR      = 5'h08;
   localparam logic [4:0] F5_MIN     = 5'h10;
   localparam logic [4:0] F5_MAX     = 5'h14;
   localparam logic [4:0] F5_MINU    = 5'h18;
   localparam logic [4:0] F5_MAXU    = 5'h1C;

   // First operation index of each group.
   localparam logic [6:0] IDX_OP_IMM    = 7'd0;
   localparam logic [6:0] IDX_OP_IMM_32 = 7'd9;
   localparam logic [6:0] IDX_LOAD      = 7'd13;
   localparam logic [6:0] IDX_FP_ARITH  = 7'd20;
   localparam logic [6:0] IDX_FCVT_S    = 7'd26;
   localparam logic [6:0] IDX_FCVT_D    = 7'd28;
   localparam logic [6:0] IDX_FCVT_I    = 7'd30;
   localparam logic [6:0] IDX_FCVT_DI   = 7'd34;
   localparam logic [6:0] IDX_FSGNJ     = 7'd38;
   localparam logic [6:0] IDX_FMINMAX   = 7'd41;
   localparam logic [6:0] IDX_FCMP      = 7'd43;
   localparam logic [6:0] IDX_FCLASS    = 7'd46;
   localparam logic [6:0] IDX_AMO_W     = 7'd48;
   localparam logic [6:0] IDX_AMO_D     = 7'd59;
   localparam logic [6:0] IDX_OP_32     = 7'd70;
   localparam logic [6:0] IDX_STORE     = 7'd98;
   localparam logic [6:0] IDX_STORE_FP  = 7'd102;
   localparam logic [6:0] IDX_BRANCH    = 7'd105;
   localparam logic [6:0] IDX_LUI       = 7'd111;
   localparam logic [6:0] IDX_AUIPC     = 7'd112;
   localparam logic [6:0] IDX_JAL       = 7'd113;

   // First index for each funct3 of the OP group.
   localparam logic [6:0] OP_BASE [8] = '{
      7'd80, 7'd83, 7'd85, 7'd87, 7'd89, 7'd91, 7'd94, 7'd96
   };

endpackage

`default_nettype wire

@@ hdl/rv64_instruction_decoder.sv @@
`default_nettype none

// Channel   Ports                                               Direction
// request   start, busy, req_instr_word                         in (busy out)
// response  rsp_valid, rsp_op_index, rsp_format_class,          out
//           rsp_illegal
//
// One instruction word is taken in every cycle; busy is always low.
// The word is registered, decoded by one pass of logic and registered again,
// so responses come back in request order.
// A synchronous reset clears both valid flags; the data registers are not reset.
// The response is shown for one cycle and cannot be held off.

module rv64_instruction_decoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [rid_pkg::WORD_W-1:0]     req_instr_word,
   output logic                                rsp_valid,
   output logic [rid_pkg::INDEX_W-1:0]         rsp_op_index,
   output logic [2:0]                          rsp_format_class,
   output logic                                rsp_illegal
);

   logic                           req_valid_ff;
   logic [rid_pkg::WORD_W-1:0]     instr_ff;
   logic                           rsp_valid_ff;
   logic [rid_pkg::INDEX_W-1:0]    op_index_ff;
   logic [rid_pkg::INDEX_W-1:0]    op_index_in;
   rid_pkg::format_class_type      format_ff;
   rid_pkg::format_class_type      format_in;
   logic                           illegal_ff;
   logic                           illegal_in;

   logic [6:0]                     opc;
   logic [2:0]                     f3;
   logic [6:0]                     f7;
   logic [4:0]                     f5;
   logic [4:0]                     rs2;
   logic [rid_pkg::INDEX_W-1:0]    idx;
   logic                           hit;
   logic [rid_pkg::INDEX_W-1:0]    op_base;
   logic [rid_pkg::INDEX_W-1:0]    amo_base;

   assign busy = 1'b0;

   assign opc = instr_ff[6:0];
   assign f3  = instr_ff[14:12];
   assign f7  = instr_ff[31:25];
   assign f5  = instr_ff[31:27];
   assign rs2 = instr_ff[24:20];

   assign op_base  = rid_pkg::OP_BASE[f3];
   assign amo_base = f3[0] ? rid_pkg::IDX_AMO_D : rid_pkg::IDX_AMO_W;

   always_comb begin
      case (opc)
         rid_pkg::OPC_OP_FP, rid_pkg::OPC_OP, rid_pkg::OPC_AMO,
         rid_pkg::OPC_OP_32: format_in = rid_pkg::FMT_R;
         rid_pkg::OPC_MADD, rid_pkg::OPC_MSUB, rid_pkg::OPC_NMSUB,
         rid_pkg::OPC_NMADD: format_in = rid_pkg::FMT_R4;
         rid_pkg::OPC_LOAD, rid_pkg::OPC_MISC_MEM, rid_pkg::OPC_JALR,
         rid_pkg::OPC_OP_IMM, rid_pkg::OPC_OP_IMM_32,
         rid_pkg::OPC_SYSTEM: format_in = rid_pkg::FMT_I;
         rid_pkg::OPC_STORE, rid_pkg::OPC_STORE_FP: format_in = rid_pkg::FMT_S;
         rid_pkg::OPC_BRANCH: format_in = rid_pkg::FMT_B;
         rid_pkg::OPC_AUIPC, rid_pkg::OPC_LUI: format_in = rid_pkg::FMT_U;
         rid_pkg::OPC_JAL: format_in = rid_pkg::FMT_J;
         default: format_in = rid_pkg::FMT_NONE;
      endcase
   end

   // Operation select. Anything that leaves hit low is reported illegal.
   always_comb begin
      idx = '0;
      hit = 1'b0;
      case (opc)
         rid_pkg::OPC_OP_IMM: begin
            hit = 1'b1;
            case (f3)
               3'd0: idx = rid_pkg::IDX_OP_IMM;
               3'd2: idx = rid_pkg::IDX_OP_IMM + 7'd1;
               3'd3: idx = rid_pkg::IDX_OP_IMM + 7'd2;
               3'd4: idx = rid_pkg::IDX_OP_IMM + 7'd3;
               3'd6: idx = rid_pkg::IDX_OP_IMM + 7'd4;
               3'd7: idx = rid_pkg::IDX_OP_IMM + 7'd5;
               3'd1: idx = rid_pkg::IDX_OP_IMM + 7'd6;
               default: begin
                  if (f7 == rid_pkg::F7_BASE) begin
                     idx = rid_pkg::IDX_OP_IMM + 7'd7;
                  end else if (f7 == rid_pkg::F7_ALT) begin
                     idx = rid_pkg::IDX_OP_IMM + 7'd8;
                  end else begin
                     hit = 1'b0;
                  end
               end
            endcase
         end
         rid_pkg::OPC_OP_IMM_32: begin
            if (f3 == 3'd0) begin
               idx = rid_pkg::IDX_OP_IMM_32;
               hit = 1'b1;
            end else if (f3 == 3'd1) begin
               idx = rid_pkg::IDX_OP_IMM_32 + 7'd1;
               hit = 1'b1;
            end else if (f3 == 3'd5 && f7 == rid_pkg::F7_BASE) begin
               idx = rid_pkg::IDX_OP_IMM_32 + 7'd2;
               hit = 1'b1;
            end else if (f3 == 3'd5 && f7 == rid_pkg::F7_ALT) begin
               idx = rid_pkg::IDX_OP_IMM_32 + 7'd3;
               hit = 1'b1;
            end
         end
         rid_pkg::OPC_LOAD: begin
            hit = 1'b1;
            case (f3)
               3'd0: idx = rid_pkg::IDX_LOAD;
               3'd1: idx = rid_pkg::IDX_LOAD + 7'd1;
               3'd2: idx = rid_pkg::IDX_LOAD + 7'd2;
               3'd4: idx = rid_pkg::IDX_LOAD + 7'd3;
               3'd5: idx = rid_pkg::IDX_LOAD + 7'd4;
               3'd6: idx = rid_pkg::IDX_LOAD + 7'd5;
               3'd3: idx = rid_pkg::IDX_LOAD + 7'd6;
               default: hit = 1'b0;
            endcase
         end
         rid_pkg::OPC_OP_FP: begin
            hit = 1'b1;
            case (f7)
               rid_pkg::F7_FADD:    idx = rid_pkg::IDX_FP_ARITH;
               rid_pkg::F7_FSUB:    idx = rid_pkg::IDX_FP_ARITH + 7'd1;
               rid_pkg::F7_FMUL:    idx = rid_pkg::IDX_FP_ARITH + 7'd2;
               rid_pkg::F7_FDIV:    idx = rid_pkg::IDX_FP_ARITH + 7'd3;
               rid_pkg::F7_FSQRT:   idx = rid_pkg::IDX_FP_ARITH + 7'd4;
               rid_pkg::F7_FMV_D_X: idx = rid_pkg::IDX_FP_ARITH + 7'd5;
               rid_pkg::F7_FCVT_S: begin
                  if (rs2 == 5'd1) begin
                     idx = rid_pkg::IDX_FCVT_S;
                  end else if (rs2 == 5'd3) begin
                     idx = rid_pkg::IDX_FCVT_S + 7'd1;
                  end else begin
                     hit = 1'b0;
                  end
               end
               rid_pkg::F7_FCVT_D: begin
                  if (rs2 == 5'd0) begin
                     idx = rid_pkg::IDX_FCVT_D;
                  end else if (rs2 == 5'd3) begin
                     idx = rid_pkg::IDX_FCVT_D + 7'd1;
                  end else begin
                     hit = 1'b0;
                  end
               end
               rid_pkg::F7_FCVT_I: begin
                  idx = rid_pkg::IDX_FCVT_I + {5'd0, rs2[1:0]};
                  hit = (rs2[4:2] == 3'd0);
               end
               rid_pkg::F7_FCVT_DI: begin
                  idx = rid_pkg::IDX_FCVT_DI + {5'd0, rs2[1:0]};
                  hit = (rs2[4:2] == 3'd0);
               end
               rid_pkg::F7_FSGNJ: begin
                  idx = rid_pkg::IDX_FSGNJ + {5'd0, f3[1:0]};
                  hit = (f3 <= 3'd2);
               end
               rid_pkg::F7_FMINMAX: begin
                  idx = rid_pkg::IDX_FMINMAX + {6'd0, f3[0]};
                  hit = (f3 <= 3'd1);
               end
               rid_pkg::F7_FCMP: begin
                  // The compare order is feq, flt, fle for funct3 of 2, 1, 0.
                  case (f3)
                     3'd2: idx = rid_pkg::IDX_FCMP;
                     3'd1: idx = rid_pkg::IDX_FCMP + 7'd1;
                     3'd0: idx = rid_pkg::IDX_FCMP + 7'd2;
                     default: hit = 1'b0;
                  endcase
               end
               rid_pkg::F7_FCLASS: begin
                  case (f3)
                     3'd1: idx = rid_pkg::IDX_FCLASS;
                     3'd0: idx = rid_pkg::IDX_FCLASS + 7'd1;
                     default: hit = 1'b0;
                  endcase
               end
               default: hit = 1'b0;
            endcase
         end
         rid_pkg::OPC_AMO: begin
            hit = (f3 == 3'd2) || (f3 == 3'd3);
            case (f5)
               rid_pkg::F5_LR:   idx = amo_base;
               rid_pkg::F5_SC:   idx = amo_base + 7'd1;
               rid_pkg::F5_SWAP: idx = amo_base + 7'd2;
               rid_pkg::F5_ADD:  idx = amo_base + 7'd3;
               rid_pkg::F5_XOR:  idx = amo_base + 7'd4;
               rid_pkg::F5_AND:  idx = amo_base + 7'd5;
               rid_pkg::F5_OR:   idx = amo_base + 7'd6;
               rid_pkg::F5_MIN:  idx = amo_base + 7'd7;
               rid_pkg::F5_MAX:  idx = amo_base + 7'd8;
               rid_pkg::F5_MINU: idx = amo_base + 7'd9;
               rid_pkg::F5_MAXU: idx = amo_base + 7'd10;
               default: hit = 1'b0;
            endcase
         end
         rid_pkg::OPC_OP_32: begin
            hit = 1'b1;
            case (f3)
               3'd0, 3'd5: begin
                  if (f7 == rid_pkg::F7_BASE) begin
                     idx = rid_pkg::IDX_OP_32;
                  end else if (f7 == rid_pkg::F7_ALT) begin
                     idx = rid_pkg::IDX_OP_32 + 7'd1;
                  end else if (f7 == rid_pkg::F7_MULDIV) begin
                     idx = rid_pkg::IDX_OP_32 + 7'd2;
                  end else begin
                     hit = 1'b0;
                  end
                  if (f3 == 3'd5) begin
                     idx = idx + 7'd3;
                  end
               end
               3'd1: idx = rid_pkg::IDX_OP_32 + 7'd6;
               3'd4: idx = rid_pkg::IDX_OP_32 + 7'd7;
               3'd6: idx = rid_pkg::IDX_OP_32 + 7'd8;
               3'd7: idx = rid_pkg::IDX_OP_32 + 7'd9;
               default: hit = 1'b0;
            endcase
         end
         rid_pkg::OPC_OP: begin
            hit = 1'b1;
            if (f7 == rid_pkg::F7_BASE) begin
               idx = op_base;
            end else if (f7 == rid_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
               idx = op_base + 7'd1;
            end else if (f7 == rid_pkg::F7_MULDIV) begin
               // Add and shift-right have a subtract or arithmetic form ahead of M.
               idx = (f3 == 3'd0 || f3 == 3'd5) ? op_base + 7'd2 : op_base + 7'd1;
            end else begin
               hit = 1'b0;
            end
         end
         rid_pkg::OPC_STORE: begin
            idx = rid_pkg::IDX_STORE + {5'd0, f3[1:0]};
            hit = (f3 <= 3'd3);
         end
         rid_pkg::OPC_STORE_FP: begin
            hit = 1'b1;
            case (f3)
               3'd2: idx = rid_pkg::IDX_STORE_FP;
               3'd3: idx = rid_pkg::IDX_STORE_FP + 7'd1;
               3'd4: idx = rid_pkg::IDX_STORE_FP + 7'd2;
               default: hit = 1'b0;
            endcase
         end
         rid_pkg::OPC_BRANCH: begin
            hit = 1'b1;
            case (f3)
               3'd0: idx = rid_pkg::IDX_BRANCH;
               3'd1: idx = rid_pkg::IDX_BRANCH + 7'd1;
               3'd4: idx = rid_pkg::IDX_BRANCH + 7'd2;
               3'd5: idx = rid_pkg::IDX_BRANCH + 7'd3;
               3'd6: idx = rid_pkg::IDX_BRANCH + 7'd4;
               3'd7: idx = rid_pkg::IDX_BRANCH + 7'd5;
               default: hit = 1'b0;
            endcase
         end
         rid_pkg::OPC_LUI: begin
            idx = rid_pkg::IDX_LUI;
            hit = 1'b1;
         end
         rid_pkg::OPC_AUIPC: begin
            idx = rid_pkg::IDX_AUIPC;
            hit = 1'b1;
         end
         rid_pkg::OPC_JAL: begin
            idx = rid_pkg::IDX_JAL;
            hit = 1'b1;
         end
         default: begin
            idx = '0;
            hit = 1'b0;
         end
      endcase
   end

   assign illegal_in  = !hit || (format_in == rid_pkg::FMT_NONE);
   assign op_index_in = illegal_in ? '0 : idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         instr_ff <= req_instr_word;
      end
      op_index_ff <= op_index_in;
      format_ff   <= format_in;
      illegal_ff  <= illegal_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_op_index     = op_index_ff;
   assign rsp_format_class = format_ff;
   assign rsp_illegal      = illegal_ff;

endmodule

`default_nettype wire
